### design/pct_pkg.sv
package pct_pkg;

  typedef enum logic [1:0] {
    OP_HEARD   = 2'd0,
    OP_REQUEST = 2'd1,
    OP_REPLY   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  localparam logic [1:0] ST_HANDLED    = 2'd0;
  localparam logic [1:0] ST_REJECTED   = 2'd1;
  localparam logic [1:0] ST_SUPPRESSED = 2'd2;

  localparam int unsigned REG_OWN_ID    = 0;
  localparam int unsigned REG_BCAST_ID  = 1;
  localparam int unsigned REG_REQ_COOL  = 2;
  localparam int unsigned REG_REP_COOL  = 3;
  localparam int unsigned REG_PRIMARY   = 4;
  localparam int unsigned REG_INVALID   = 5;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] node;
    logic [47:0] now_ms;
    logic        info_port;
    logic        user_decoded;
    logic        request_id_nonzero;
    logic [7:0]  chan_num;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       send_request;
    logic       send_reply;
    logic [7:0] out_channel;
    logic       new_user_seen;
    logic [7:0] slot_used;
  } out_word_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic      rejected;
    in_word_t  item;
  } job_t;

endpackage

### design/pct_if.sv
interface pct_in_if import pct_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface pct_out_if import pct_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

### design/pct_front.sv
module pct_front import pct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  input  logic [31:0] own_id,
  input  logic [31:0] bcast_id,
  output logic       q_valid,
  input  logic       q_ready,
  output job_t       q_job
);
  // Two-entry queue between front and back.
  job_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  job_t       job;
  logic       push, pop;

  always_comb begin
    job.item = in_word;
    job.rejected = (in_word.op == OP_UNUSED) || (in_word.node == 32'd0) ||
                   (in_word.node == own_id) ||
                   ((in_word.op == OP_REQUEST) && (in_word.node == bcast_id));
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_job    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= job;
    end
  end
endmodule

### design/pct_back.sv
module pct_back import pct_pkg::*; #(
  parameter int unsigned PEER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  job_t        q_job,
  input  logic [31:0] req_cool,
  input  logic [31:0] rep_cool,
  input  logic [7:0]  primary_ch,
  input  logic [7:0]  invalid_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word
);
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  localparam int unsigned SW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam logic [SW:0] LAST = (SW+1)'(PEER_SLOTS - 1);

  state_t state_r, state_nxt;
  job_t   job_r;
  logic [31:0] id_r   [PEER_SLOTS];
  logic [47:0] seen_r [PEER_SLOTS];
  logic [47:0] lreq_r [PEER_SLOTS];
  logic [47:0] lrep_r [PEER_SLOTS];
  logic [PEER_SLOTS-1:0] known_r, rstamp_r, pstamp_r;
  logic [SW:0]   idx_r;
  logic [SW-1:0] oldest_r, hit_r;
  logic          fill_r;
  out_word_t     res_r;

  logic [SW-1:0] ix;
  logic [SW-1:0] slot;
  logic          found_match, found_empty, last;
  logic          heard, learn, known_now, req_ok, rep_ok, do_req, do_rep;
  logic [47:0]   now;
  logic [48:0]   dreq, drep;

  assign ix = idx_r[SW-1:0];
  assign found_match = id_r[ix] == job_r.item.node;
  assign found_empty = id_r[ix] == 32'd0;
  assign last = (idx_r == LAST);
  assign now = job_r.item.now_ms;
  assign slot = hit_r;

  // Cooldown elapsed when unstamped, or time advanced by at least the gap.
  always_comb begin
    dreq = {1'b0, now} - {1'b0, lreq_r[slot]};
    drep = {1'b0, now} - {1'b0, lrep_r[slot]};
    req_ok = fill_r || !rstamp_r[slot] ||
             (!dreq[48] && (dreq[47:0] >= {16'd0, req_cool}));
    rep_ok = fill_r || !pstamp_r[slot] ||
             (!drep[48] && (drep[47:0] >= {16'd0, rep_cool}));
    heard = job_r.item.op == OP_HEARD;
    learn = job_r.item.info_port && job_r.item.user_decoded;
    known_now = !fill_r && known_r[slot];
    do_req = heard ? (!(known_now || learn) && !job_r.item.info_port && req_ok)
                   : ((job_r.item.op == OP_REQUEST) && req_ok);
    do_rep = (job_r.item.op == OP_REPLY) && rep_ok;
  end

  assign q_ready   = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_word  = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_valid) state_nxt = q_job.rejected ? S_OUT : S_SCAN;
      S_SCAN:  if (found_match || found_empty || last) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      for (int i = 0; i < PEER_SLOTS; i++) id_r[i] <= 32'd0;
      known_r  <= '0;
      rstamp_r <= '0;
      pstamp_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_APPLY) begin
        seen_r[slot] <= now;
        if (fill_r) id_r[slot] <= job_r.item.node;
        // A fresh slot starts unknown and unstamped unless this word sets them.
        if (fill_r || (heard && learn)) known_r[slot] <= heard && learn;
        if (fill_r || do_req) rstamp_r[slot] <= do_req;
        if (fill_r || do_rep) pstamp_r[slot] <= do_rep;
        if (do_req) lreq_r[slot] <= now;
        if (do_rep) lrep_r[slot] <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        job_r    <= q_job;
        idx_r    <= '0;
        oldest_r <= '0;
        res_r    <= {ST_REJECTED, 19'd0};
      end
      S_SCAN: begin
        if (found_match) begin
          hit_r <= ix; fill_r <= 1'b0;
        end else if (found_empty) begin
          hit_r <= ix; fill_r <= 1'b1;
        end else if (last) begin
          hit_r  <= (seen_r[ix] < seen_r[oldest_r]) ? ix : oldest_r;
          fill_r <= 1'b1;
        end else begin
          if (seen_r[ix] < seen_r[oldest_r]) oldest_r <= ix;
        end
        idx_r <= idx_r + (SW+1)'(1);
      end
      S_APPLY: begin
        res_r.slot_used     <= 8'(slot);
        res_r.send_request  <= do_req;
        res_r.send_reply    <= do_rep;
        res_r.new_user_seen <= heard && learn &&
                               (job_r.item.request_id_nonzero || !known_now);
        res_r.status <= (heard || do_req || do_rep) ? ST_HANDLED : ST_SUPPRESSED;
        if (do_rep) res_r.out_channel <= job_r.item.chan_num;
        else if (do_req && heard)
          res_r.out_channel <= (job_r.item.chan_num != invalid_ch) ?
                               job_r.item.chan_num : primary_ch;
        else res_r.out_channel <= 8'd0;
      end
      S_OUT: ;
      default: ;
    endcase
  end
endmodule

### design/pct_regs.sv
module pct_regs import pct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [31:0] own_id,
  output logic [31:0] bcast_id,
  output logic [31:0] req_cool,
  output logic [31:0] rep_cool,
  output logic [7:0]  primary_ch,
  output logic [7:0]  invalid_ch
);
  logic [2:0] ri;
  logic       we;
  assign ri = paddr[4:2];
  assign we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id     <= 32'd0;
      bcast_id   <= 32'hFFFF_FFFF;
      req_cool   <= 32'd300000;
      rep_cool   <= 32'd300000;
      primary_ch <= 8'd0;
      invalid_ch <= 8'd255;
    end else if (we) begin
      unique case (32'(ri))
        REG_OWN_ID:   own_id     <= pwdata;
        REG_BCAST_ID: bcast_id   <= pwdata;
        REG_REQ_COOL: req_cool   <= pwdata;
        REG_REP_COOL: rep_cool   <= pwdata;
        REG_PRIMARY:  primary_ch <= pwdata[7:0];
        REG_INVALID:  invalid_ch <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (32'(ri))
      REG_OWN_ID:   prdata = own_id;
      REG_BCAST_ID: prdata = bcast_id;
      REG_REQ_COOL: prdata = req_cool;
      REG_REP_COOL: prdata = rep_cool;
      REG_PRIMARY:  prdata = {24'd0, primary_ch};
      REG_INVALID:  prdata = {24'd0, invalid_ch};
      default:      prdata = 32'd0;
    endcase
  end
endmodule

### design/peer_cooldown_table_core.sv
// The back part loads each accepted word from the queue, scans the table
// one slot per cycle until a match, an empty slot or the last slot, then
// updates the slot and shows the result; a rejected word skips the scan and
// the update. A new word is loaded only after the result has been taken.
// Reset (rst_n, synchronous): the table empties at once and registers
// return to their defaults; no clearing pass.
module peer_cooldown_table_core import pct_pkg::*; #(
  parameter int unsigned PEER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pct_in_if.sink      in_ch,
  pct_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [31:0] own_id, bcast_id, req_cool, rep_cool;
  logic [7:0]  primary_ch, invalid_ch;
  logic        q_valid, q_ready;
  job_t        q_job;

  assign cfg_pready = 1'b1;

  pct_regs u_regs (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .own_id, .bcast_id, .req_cool, .rep_cool, .primary_ch, .invalid_ch
  );

  pct_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_word(in_ch.word),
    .own_id, .bcast_id, .q_valid, .q_ready, .q_job
  );

  pct_back #(.PEER_SLOTS(PEER_SLOTS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_job,
    .req_cool, .rep_cool, .primary_ch, .invalid_ch,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(out_ch.word)
  );
endmodule

### design/pct_checker.sv
module pct_checker import pct_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result dropped or changed while stalled");

  a_one_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.send_request && out_word.send_reply))
    else $error("both request and reply flagged");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_REJECTED |->
      !out_word.send_request && !out_word.send_reply && out_word.slot_used == 8'd0)
    else $error("rejected word carries a send or a slot");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status == ST_HANDLED || out_word.status == ST_REJECTED ||
                   out_word.status == ST_SUPPRESSED))
    else $error("undefined status code");
endmodule

bind peer_cooldown_table_core pct_checker u_pct_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_word(out_ch.word)
);

### tb/sv/peer_cooldown_table_core_tb.sv
`timescale 1ns / 100ps

module peer_cooldown_table_core_tb;
  import pct_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pct_in_if in_ch ();
  pct_out_if out_ch ();

  peer_cooldown_table_core #(.PEER_SLOTS(SLOTS)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Mirror of the peer table that predicts each result word.
  class cooldown_scoreboard;
    logic [31:0] own_id, bcast_id, req_cool, rep_cool;
    logic [7:0] primary_ch, invalid_ch;
    logic [31:0] ids[SLOTS];
    logic [47:0] seen[SLOTS], last_req[SLOTS], last_rep[SLOTS];
    bit known[SLOTS], req_ok[SLOTS], rep_ok[SLOTS];
    out_word_t pending[$];
    int errors;
    int checked;
    int sends;

    function new();
      own_id = 0; bcast_id = '1; req_cool = 300000; rep_cool = 300000;
      primary_ch = 0; invalid_ch = 8'hFF;
      foreach (ids[i]) begin
        ids[i] = 0; known[i] = 0; req_ok[i] = 0; rep_ok[i] = 0;
        seen[i] = 0; last_req[i] = 0; last_rep[i] = 0;
      end
      errors = 0; checked = 0; sends = 0;
    endfunction

    function void set_reg(int unsigned idx, logic [31:0] v);
      unique case (idx)
        REG_OWN_ID:   own_id = v;
        REG_BCAST_ID: bcast_id = v;
        REG_REQ_COOL: req_cool = v;
        REG_REP_COOL: rep_cool = v;
        REG_PRIMARY:  primary_ch = v[7:0];
        REG_INVALID:  invalid_ch = v[7:0];
        default: ;
      endcase
    endfunction

    function bit elapsed(bit stamped, logic [47:0] stamp, logic [47:0] now,
                         logic [31:0] gap);
      if (!stamped) return 1;
      return now >= stamp && (now - stamp) >= {16'd0, gap};
    endfunction

    function int unsigned locate(logic [31:0] node, logic [47:0] now);
      int unsigned oldest;
      int unsigned hit;
      oldest = 0;
      hit = SLOTS;
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (ids[i] == node) begin
          seen[i] = now;
          return i;
        end
        if (ids[i] == 0) begin
          hit = i;
          break;
        end
        if (seen[i] < seen[oldest]) oldest = i;
      end
      if (hit == SLOTS) hit = oldest;
      ids[hit] = node; seen[hit] = now; last_req[hit] = 0; last_rep[hit] = 0;
      known[hit] = 0; req_ok[hit] = 0; rep_ok[hit] = 0;
      return hit;
    endfunction

    function void note_input(in_word_t w);
      out_word_t r;
      int unsigned s;
      r = '0;
      if (w.op == OP_UNUSED || w.node == 0 || w.node == own_id ||
          (w.op == OP_REQUEST && w.node == bcast_id)) begin
        r.status = ST_REJECTED;
      end else begin
        s = locate(w.node, w.now_ms);
        r.slot_used = s[7:0];
        r.status = ST_HANDLED;
        if (w.op == OP_HEARD) begin
          if (w.info_port && w.user_decoded) begin
            r.new_user_seen = w.request_id_nonzero || !known[s];
            known[s] = 1;
          end
          if (!known[s] && !w.info_port &&
              elapsed(req_ok[s], last_req[s], w.now_ms, req_cool)) begin
            r.send_request = 1;
            r.out_channel = (w.chan_num != invalid_ch) ? w.chan_num : primary_ch;
            req_ok[s] = 1; last_req[s] = w.now_ms;
          end
        end else if (w.op == OP_REQUEST) begin
          if (elapsed(req_ok[s], last_req[s], w.now_ms, req_cool)) begin
            r.send_request = 1;
            req_ok[s] = 1; last_req[s] = w.now_ms;
          end else begin
            r.status = ST_SUPPRESSED;
          end
        end else begin
          if (elapsed(rep_ok[s], last_rep[s], w.now_ms, rep_cool)) begin
            r.send_reply = 1;
            r.out_channel = w.chan_num;
            rep_ok[s] = 1; last_rep[s] = w.now_ms;
          end else begin
            r.status = ST_SUPPRESSED;
          end
        end
      end
      if (r.send_request || r.send_reply) sends++;
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("mismatch at result %0d: %s expected %0h got %0h",
               checked, what, exp_v, got_v);
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t exp_w;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result word", 32'd0, 32'(got));
        return;
      end
      exp_w = pending.pop_front();
      if (got.status !== exp_w.status)
        report_mismatch("status", 32'(exp_w.status), 32'(got.status));
      if (got.send_request !== exp_w.send_request)
        report_mismatch("send_request", 32'(exp_w.send_request), 32'(got.send_request));
      if (got.send_reply !== exp_w.send_reply)
        report_mismatch("send_reply", 32'(exp_w.send_reply), 32'(got.send_reply));
      if (got.out_channel !== exp_w.out_channel)
        report_mismatch("out_channel", 32'(exp_w.out_channel), 32'(got.out_channel));
      if (got.new_user_seen !== exp_w.new_user_seen)
        report_mismatch("new_user_seen", 32'(exp_w.new_user_seen),
                        32'(got.new_user_seen));
      if (got.slot_used !== exp_w.slot_used)
        report_mismatch("slot_used", 32'(exp_w.slot_used), 32'(got.slot_used));
    endtask
  endclass

  cooldown_scoreboard table_sb;
  int cycles;
  int words_sent;
  bit long_hold;
  logic [47:0] clock_ms;
  logic [31:0] peer_pool[24];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** peer_cooldown_table_core: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin
    int unsigned gap;
    out_ch.ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      table_sb.check_result(out_ch.word);
    end
  end

  task automatic apb_write(int unsigned idx, logic [31:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= 5'(idx * 4); cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    table_sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // The word stays offered after acceptance until the next gap or drain.
  task automatic send_word(in_word_t w, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    table_sb.note_input(w);
    words_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (table_sb.pending.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic in_word_t make_word(op_t op, logic [31:0] node, int unsigned step);
    in_word_t w;
    clock_ms = clock_ms + 48'(step);
    w.op = op;
    w.node = node;
    w.now_ms = clock_ms;
    w.info_port = 1'($urandom_range(0, 1));
    w.user_decoded = 1'($urandom_range(0, 1));
    w.request_id_nonzero = 1'($urandom_range(0, 1));
    w.chan_num = ($urandom_range(0, 3) == 0) ? table_sb.invalid_ch :
                 8'($urandom_range(0, 255));
    return w;
  endfunction

  task automatic random_phase(int n, int unsigned max_step);
    in_word_t w;
    logic [31:0] node;
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) node = 0;
      else if (pick < 6) node = table_sb.own_id;
      else if (pick < 9) node = table_sb.bcast_id;
      else if (pick < 13) node = $urandom;
      else node = peer_pool[$urandom_range(0, 23)];
      pick = $urandom_range(0, 99);
      w = make_word(pick < 2 ? OP_UNUSED : pick < 40 ? OP_HEARD :
                    pick < 70 ? OP_REQUEST : OP_REPLY,
                    node, $urandom_range(0, max_step));
      // Occasionally let time step backwards.
      if ($urandom_range(0, 49) == 0 && clock_ms > 1000)
        w.now_ms = clock_ms - 48'($urandom_range(1, 1000));
      send_word(w, 0);
    end
  endtask

  initial begin
    in_word_t w;
    table_sb = new();
    words_sent = 0; long_hold = 0; clock_ms = 0;
    rst_n = 0;
    in_ch.valid = 0; in_ch.word = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    foreach (peer_pool[i]) peer_pool[i] = (i < 4) ? 32'hFFFF_FFF0 + i : $urandom | 32'h100;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: defaults, rejection cases, cooldown edges, channel fallback.
    send_word(make_word(OP_HEARD, 0, 0), 1);
    send_word(make_word(OP_REQUEST, 32'hFFFF_FFFF, 0), 1);
    send_word(make_word(OP_REPLY, 32'hFFFF_FFFF, 0), 1);
    send_word(make_word(OP_UNUSED, 32'h1234, 0), 1);
    w = make_word(OP_HEARD, 32'h1234, 5);
    w.info_port = 0; w.chan_num = 8'hFF;
    send_word(w, 0);
    send_word(make_word(OP_REQUEST, 32'h1234, 299999), 0);
    send_word(make_word(OP_REQUEST, 32'h1234, 1), 0);
    send_word(make_word(OP_REPLY, 32'h1234, 0), 0);
    send_word(make_word(OP_REPLY, 32'h1234, 0), 0);
    w = make_word(OP_HEARD, 32'h1234, 0);
    w.info_port = 1; w.user_decoded = 1; w.request_id_nonzero = 0;
    send_word(w, 0);
    send_word(w, 0);
    for (int i = 0; i < 18; i++) send_word(make_word(OP_HEARD, 32'h5000 + i, 1), 1);
    drain();

    apb_write(REG_OWN_ID, 32'h1234);
    apb_write(REG_BCAST_ID, 32'h0);
    apb_write(REG_REQ_COOL, 0);
    apb_write(REG_REP_COOL, 0);
    apb_write(REG_PRIMARY, 32'hFF);
    apb_write(REG_INVALID, 32'h00);
    send_word(make_word(OP_REQUEST, 32'h1234, 0), 0);
    random_phase(400, 3);
    drain();

    apb_write(REG_OWN_ID, peer_pool[5]);
    apb_write(REG_BCAST_ID, peer_pool[0]);
    apb_write(REG_REQ_COOL, 32'hFFFF_FFFF);
    apb_write(REG_REP_COOL, 32'h40);
    apb_write(REG_PRIMARY, 32'h5A);
    apb_write(REG_INVALID, 32'hA5);
    random_phase(400, 40);
    // Hold off the result side while words keep coming.
    long_hold = 1;
    random_phase(60, 40);
    drain();

    apb_write(REG_OWN_ID, 32'hFFFF_FFFF);
    apb_write(REG_BCAST_ID, 32'hFFFF_FFFF);
    apb_write(REG_REQ_COOL, 100);
    apb_write(REG_REP_COOL, 32'hFFFF_FFFF);
    apb_write(REG_INVALID, 32'hFF);
    apb_write(REG_PRIMARY, 32'h00);
    random_phase(400, 120);
    // Time near the top of its range.
    clock_ms = 48'hFFFF_FFFF_0000;
    random_phase(100, 32'h0FFF_FFFF);
    drain();

    apb_write(REG_REQ_COOL, 300000);
    apb_write(REG_REP_COOL, 300000);
    random_phase(400, 50000);
    drain();

    $display("run covered %0d words, %0d results checked, %0d sends predicted",
             words_sent, table_sb.checked, table_sb.sends);
    if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
      $display("** peer_cooldown_table_core: PASSED **");
    end else begin
      $display("** peer_cooldown_table_core: FAILED **");
    end
    $finish;
  end

endmodule
